@@ hdl/detection_persistence_filter_defines.svh @@
// Assertion macros for the detection persistence filter checker.
`ifndef DETECTION_PERSISTENCE_FILTER_DEFINES_SVH
`define DETECTION_PERSISTENCE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpf checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define DPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpf checker: next-cycle property failed");

`endif

@@ hdl/dpf_pkg.sv @@
// Types, constants and codes shared by the detection persistence filter modules.
package dpf_pkg;

  localparam int LABEL_COUNT_DEF = 52;
  localparam int COUNT_BITS_DEF  = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam int OP_W       = 3;
  localparam int LABEL_W    = 6;
  localparam int CONF_W     = 16;
  localparam int COORD_W    = 12;
  localparam int CNT_CFG_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OPC_DETECT    = 3'd0;
  localparam logic [OP_W-1:0] OPC_END_FRAME = 3'd1;
  localparam logic [OP_W-1:0] OPC_EXT_UPPER = 3'd2;
  localparam logic [OP_W-1:0] OPC_EXT_LOWER = 3'd3;
  localparam logic [OP_W-1:0] OPC_CLEAR     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONF     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

  localparam logic [CONF_W-1:0]    MIN_CONF_RST     = 16'd32768;
  localparam logic [CNT_CFG_W-1:0] THRESHOLD_RST    = 4'd5;
  localparam logic [CNT_CFG_W-1:0] COUNT_MAX_RST    = 4'd10;
  localparam logic [CNT_CFG_W-1:0] COUNT_STEP_RST   = 4'd2;
  localparam logic [COORD_W-1:0]   FRAME_HEIGHT_RST = 12'd640;

  typedef enum logic [2:0] {
    CMD_DETECT,
    CMD_END_FRAME,
    CMD_EXT_UPPER,
    CMD_EXT_LOWER,
    CMD_CLEAR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [LABEL_W-1:0]   label;
    logic [CONF_W-1:0]    conf;
    logic                 lower;
  } cmd_t;

  typedef struct packed {
    logic [CONF_W-1:0]    min_conf;
    logic [CNT_CFG_W-1:0] threshold;
    logic [CNT_CFG_W-1:0] count_max;
    logic [CNT_CFG_W-1:0] count_step;
    logic [COORD_W-1:0]   frame_height;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DETECT,
    BK_SWEEP,
    BK_FLUSH
  } back_state_e;

endpackage

@@ hdl/dpf_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module dpf_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/dpf_queue.sv @@
// Short command queue between the classifying front and the executing back.
module dpf_queue #(
  parameter int DEPTH = dpf_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dpf_pkg::cmd_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output dpf_pkg::cmd_t data_o,
  input  logic          pop_i
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  dpf_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/dpf_front.sv @@
// Input front end: accepts words, filters detections and classifies the box half.
module dpf_front #(
  parameter int LABEL_COUNT = dpf_pkg::LABEL_COUNT_DEF
) (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dpf_pkg::OP_W-1:0]      in_op_i,
  input  logic [dpf_pkg::LABEL_W-1:0]   in_label_i,
  input  logic [dpf_pkg::CONF_W-1:0]    in_confidence_i,
  input  logic [dpf_pkg::COORD_W-1:0]   in_box_top_i,
  input  logic [dpf_pkg::COORD_W-1:0]   in_box_height_i,
  input  dpf_pkg::cfg_t                 cfg_i,
  output logic                          q_push_o,
  output dpf_pkg::cmd_t                 q_data_o,
  input  logic                          q_full_i
);

  localparam int SUM_W = dpf_pkg::COORD_W + 2;

  logic             accept;
  logic             keep;
  logic [SUM_W-1:0] centre2;
  logic             det_ok;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign centre2 = {1'b0, in_box_top_i, 1'b0} + {2'b00, in_box_height_i};
  assign det_ok  = (32'(in_label_i) < 32'(LABEL_COUNT)) &&
                   (in_confidence_i >= cfg_i.min_conf);

  always_comb begin
    q_data_o.op    = dpf_pkg::CMD_DETECT;
    q_data_o.label = in_label_i;
    q_data_o.conf  = in_confidence_i;
    q_data_o.lower = !(centre2 < {2'b00, cfg_i.frame_height});
    keep           = 1'b1;
    case (in_op_i)
      dpf_pkg::OPC_DETECT: begin
        keep = det_ok;
      end
      dpf_pkg::OPC_END_FRAME: begin
        q_data_o.op = dpf_pkg::CMD_END_FRAME;
      end
      dpf_pkg::OPC_EXT_UPPER: begin
        q_data_o.op = dpf_pkg::CMD_EXT_UPPER;
      end
      dpf_pkg::OPC_EXT_LOWER: begin
        q_data_o.op = dpf_pkg::CMD_EXT_LOWER;
      end
      dpf_pkg::OPC_CLEAR: begin
        q_data_o.op = dpf_pkg::CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && keep;

endmodule

@@ hdl/dpf_back.sv @@
// Execution back end: per-label RAM updates, frame sweeps and extract output.
module dpf_back #(
  parameter int LABEL_COUNT = dpf_pkg::LABEL_COUNT_DEF,
  parameter int COUNT_BITS  = dpf_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpf_pkg::cfg_t               cfg_i,
  input  logic                        cmd_valid_i,
  input  dpf_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dpf_pkg::LABEL_W-1:0] out_confirmed_label_o,
  output logic                        out_bank_o,
  output logic                        out_last_o
);

  localparam int IDX_W     = $clog2(LABEL_COUNT);
  localparam int CONF_W    = dpf_pkg::CONF_W;
  localparam int ROW_W     = CONF_W + 1 + 2 * COUNT_BITS + 2;
  localparam int SUM_W     = (COUNT_BITS > dpf_pkg::CNT_CFG_W) ? COUNT_BITS + 1
                                                              : dpf_pkg::CNT_CFG_W + 1;
  localparam int CNT_LIMIT = (1 << COUNT_BITS) - 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LABEL_COUNT - 1);

  dpf_pkg::back_state_e state_q, state_d;
  dpf_pkg::cmd_t        cmd_q, cmd_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic [LABEL_COUNT-1:0] vld_q, vld_d;
  logic                 rd_vld_q, rd_vld_d;

  logic                 out_valid_q, out_valid_d;
  logic [dpf_pkg::LABEL_W-1:0] out_label_q, out_label_d;
  logic                 out_bank_q, out_bank_d;
  logic                 out_last_q, out_last_d;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ROW_W-1:0]     rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ROW_W-1:0]     wr_data;
  logic                 clr_all;

  logic                 push;
  logic [IDX_W-1:0]     push_idx;
  logic                 push_last;
  logic                 push_ok;

  logic [ROW_W-1:0]      row;
  logic [CONF_W-1:0]     r_conf;
  logic                  r_lower;
  logic [COUNT_BITS-1:0] r_ucnt;
  logic [COUNT_BITS-1:0] r_lcnt;
  logic                  r_useen;
  logic                  r_lseen;

  logic [COUNT_BITS-1:0] u_dec;
  logic [COUNT_BITS-1:0] l_dec;
  logic [SUM_W-1:0]      limit;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      sat;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic                  has_det;
  logic [ROW_W-1:0]      eof_row;

  logic                  ext_lower;
  logic [COUNT_BITS-1:0] ext_cnt;
  logic                  ext_seen;
  logic                  ext_hit;
  logic                  ext_block;
  logic [ROW_W-1:0]      ext_row;
  logic                  det_hit;
  logic [ROW_W-1:0]      det_row;
  logic                  idx_last;
  logic                  is_eof;

  dpf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (LABEL_COUNT)
  ) u_dpf_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign row = rd_vld_q ? rd_data : '0;
  assign {r_conf, r_lower, r_ucnt, r_lcnt, r_useen, r_lseen} = row;

  assign u_dec   = r_ucnt - COUNT_BITS'(r_ucnt != '0);
  assign l_dec   = r_lcnt - COUNT_BITS'(r_lcnt != '0);
  assign limit   = (SUM_W'(cfg_i.count_max) > SUM_W'(CNT_LIMIT)) ? SUM_W'(CNT_LIMIT)
                                                                : SUM_W'(cfg_i.count_max);
  assign sum     = SUM_W'(r_lower ? l_dec : u_dec) + SUM_W'(cfg_i.count_step);
  assign sat     = (sum > limit) ? limit : sum;
  assign inc_cnt = COUNT_BITS'(sat);
  assign has_det = (r_conf != '0);
  assign eof_row = {CONF_W'(0), 1'b0,
                    (has_det && !r_lower) ? inc_cnt : u_dec,
                    (has_det && r_lower) ? inc_cnt : l_dec,
                    r_useen, r_lseen};

  assign is_eof    = (cmd_q.op == dpf_pkg::CMD_END_FRAME);
  assign ext_lower = (cmd_q.op == dpf_pkg::CMD_EXT_LOWER);
  assign ext_cnt   = ext_lower ? r_lcnt : r_ucnt;
  assign ext_seen  = ext_lower ? r_lseen : r_useen;
  assign ext_hit   = (SUM_W'(ext_cnt) > SUM_W'(cfg_i.threshold)) && !ext_seen;
  assign ext_row   = {r_conf, r_lower, r_ucnt, r_lcnt,
                      r_useen | !ext_lower, r_lseen | ext_lower};
  assign push_ok   = !out_valid_q || !out_stall_i;
  assign ext_block = ext_hit && pend_vld_q && !push_ok;

  assign det_hit  = (cmd_q.conf > r_conf);
  assign det_row  = {cmd_q.conf, cmd_q.lower, r_ucnt, r_lcnt, r_useen, r_lseen};
  assign idx_last = (idx_q == IDX_LAST);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dpf_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            dpf_pkg::CMD_DETECT:    state_d = dpf_pkg::BK_DETECT;
            dpf_pkg::CMD_END_FRAME: state_d = dpf_pkg::BK_SWEEP;
            dpf_pkg::CMD_EXT_UPPER: state_d = dpf_pkg::BK_SWEEP;
            dpf_pkg::CMD_EXT_LOWER: state_d = dpf_pkg::BK_SWEEP;
            default:                state_d = dpf_pkg::BK_IDLE;
          endcase
        end
      end
      dpf_pkg::BK_DETECT: begin
        state_d = dpf_pkg::BK_IDLE;
      end
      dpf_pkg::BK_SWEEP: begin
        if (is_eof) begin
          if (idx_last) begin
            state_d = dpf_pkg::BK_IDLE;
          end
        end else if (!ext_block && idx_last) begin
          state_d = dpf_pkg::BK_FLUSH;
        end
      end
      dpf_pkg::BK_FLUSH: begin
        if (!pend_vld_q || push_ok) begin
          state_d = dpf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = dpf_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    wr_addr    = idx_q;
    wr_data    = eof_row;
    clr_all    = 1'b0;
    push       = 1'b0;
    push_idx   = pend_idx_q;
    push_last  = 1'b0;
    case (state_q)
      dpf_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          idx_d      = '0;
          pend_vld_d = 1'b0;
          case (cmd_i.op)
            dpf_pkg::CMD_DETECT: begin
              rd_en   = 1'b1;
              rd_addr = IDX_W'(cmd_i.label);
            end
            dpf_pkg::CMD_END_FRAME, dpf_pkg::CMD_EXT_UPPER, dpf_pkg::CMD_EXT_LOWER: begin
              rd_en   = 1'b1;
              rd_addr = '0;
            end
            dpf_pkg::CMD_CLEAR: begin
              clr_all = 1'b1;
            end
            default: begin
              clr_all = 1'b0;
            end
          endcase
        end
      end
      dpf_pkg::BK_DETECT: begin
        wr_addr = IDX_W'(cmd_q.label);
        wr_data = det_row;
        wr_en   = det_hit;
      end
      dpf_pkg::BK_SWEEP: begin
        if (is_eof || !ext_block) begin
          if (is_eof) begin
            wr_en = 1'b1;
          end else if (ext_hit) begin
            wr_en      = 1'b1;
            wr_data    = ext_row;
            push       = pend_vld_q;
            pend_vld_d = 1'b1;
            pend_idx_d = idx_q;
          end
          if (!idx_last) begin
            idx_d   = idx_q + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q + IDX_W'(1);
          end
        end
      end
      dpf_pkg::BK_FLUSH: begin
        if (pend_vld_q && push_ok) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        clr_all = 1'b0;
      end
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (clr_all) begin
      vld_d = '0;
    end else if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  assign rd_vld_d = rd_en ? vld_q[rd_addr] : rd_vld_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_label_d = out_label_q;
    out_bank_d  = out_bank_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_label_d = dpf_pkg::LABEL_W'(push_idx);
      out_bank_d  = ext_lower;
      out_last_d  = push_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpf_pkg::BK_IDLE;
      idx_q       <= '0;
      pend_vld_q  <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_vld_q  <= pend_vld_d;
      vld_q       <= vld_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pend_idx_q  <= pend_idx_d;
    out_label_q <= out_label_d;
    out_bank_q  <= out_bank_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o           = out_valid_q;
  assign out_confirmed_label_o = out_label_q;
  assign out_bank_o            = out_bank_q;
  assign out_last_o            = out_last_q;

endmodule

@@ hdl/detection_persistence_filter.sv @@
// Top level of the detection persistence filter: configuration registers and wiring.
// A per-label detection qualifier. Words enter a two-entry command queue and are
// executed by a back end that keeps one row per label in a single RAM with one read
// and one write port. A detection word is executed as a row read and then a compare
// and write, and the back end takes no new word until it has finished. End of frame
// and extract words sweep every label row, and an extract then flushes its final
// result, waiting while out_stall_i holds a result. A clear word is handled as soon
// as it is popped. Rows carry valid bits, so reset and clear take effect at once with
// no clearing pass. Results of one extract come in ascending label order, and
// out_last_o marks the final one; an extract with nothing to confirm gives no result.
// The configuration port is always ready; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module detection_persistence_filter #(
  parameter int LABEL_COUNT = dpf_pkg::LABEL_COUNT_DEF,
  parameter int COUNT_BITS  = dpf_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dpf_pkg::OP_W-1:0]        in_op_i,
  input  logic [dpf_pkg::LABEL_W-1:0]     in_label_i,
  input  logic [dpf_pkg::CONF_W-1:0]      in_confidence_i,
  input  logic [dpf_pkg::COORD_W-1:0]     in_box_top_i,
  input  logic [dpf_pkg::COORD_W-1:0]     in_box_height_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dpf_pkg::LABEL_W-1:0]     out_confirmed_label_o,
  output logic                            out_bank_o,
  output logic                            out_last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  dpf_pkg::cfg_t cfg_q, cfg_d;
  logic          q_push;
  dpf_pkg::cmd_t q_wdata;
  logic          q_full;
  logic          q_valid;
  dpf_pkg::cmd_t q_rdata;
  logic          q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dpf_pkg::CFG_MIN_CONF:     cfg_d.min_conf     = cfg_data_i;
        dpf_pkg::CFG_THRESHOLD:    cfg_d.threshold    = dpf_pkg::CNT_CFG_W'(cfg_data_i);
        dpf_pkg::CFG_COUNT_MAX:    cfg_d.count_max    = dpf_pkg::CNT_CFG_W'(cfg_data_i);
        dpf_pkg::CFG_COUNT_STEP:   cfg_d.count_step   = dpf_pkg::CNT_CFG_W'(cfg_data_i);
        dpf_pkg::CFG_FRAME_HEIGHT: cfg_d.frame_height = dpf_pkg::COORD_W'(cfg_data_i);
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_conf     <= dpf_pkg::MIN_CONF_RST;
      cfg_q.threshold    <= dpf_pkg::THRESHOLD_RST;
      cfg_q.count_max    <= dpf_pkg::COUNT_MAX_RST;
      cfg_q.count_step   <= dpf_pkg::COUNT_STEP_RST;
      cfg_q.frame_height <= dpf_pkg::FRAME_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dpf_front #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_dpf_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_op_i         (in_op_i),
    .in_label_i      (in_label_i),
    .in_confidence_i (in_confidence_i),
    .in_box_top_i    (in_box_top_i),
    .in_box_height_i (in_box_height_i),
    .cfg_i           (cfg_q),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata),
    .q_full_i        (q_full)
  );

  dpf_queue #(
    .DEPTH (dpf_pkg::QUEUE_DEPTH)
  ) u_dpf_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_rdata),
    .pop_i       (q_pop)
  );

  dpf_back #(
    .LABEL_COUNT (LABEL_COUNT),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dpf_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .cmd_valid_i           (q_valid),
    .cmd_i                 (q_rdata),
    .cmd_pop_o             (q_pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_confirmed_label_o (out_confirmed_label_o),
    .out_bank_o            (out_bank_o),
    .out_last_o            (out_last_o)
  );

endmodule

@@ hdl/dpf_checker.sv @@
// Port-level checker for the detection persistence filter, bound to the top level.
`include "detection_persistence_filter_defines.svh"

module dpf_checker #(
  parameter int LABEL_COUNT = dpf_pkg::LABEL_COUNT_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [dpf_pkg::OP_W-1:0]        in_op_i,
  input logic [dpf_pkg::LABEL_W-1:0]     in_label_i,
  input logic [dpf_pkg::CONF_W-1:0]      in_confidence_i,
  input logic [dpf_pkg::COORD_W-1:0]     in_box_top_i,
  input logic [dpf_pkg::COORD_W-1:0]     in_box_height_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [dpf_pkg::LABEL_W-1:0]     out_confirmed_label_o,
  input logic                            out_bank_o,
  input logic                            out_last_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [dpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [dpf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                        out_acc;
  logic                        run_open_q, run_open_d;
  logic                        run_bank_q, run_bank_d;
  logic [dpf_pkg::LABEL_W-1:0] run_label_q, run_label_d;

  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    run_open_d  = run_open_q;
    run_bank_d  = run_bank_q;
    run_label_d = run_label_q;
    if (out_acc) begin
      run_open_d  = !out_last_o;
      run_bank_d  = out_bank_o;
      run_label_d = out_confirmed_label_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q  <= 1'b0;
      run_bank_q  <= 1'b0;
      run_label_q <= '0;
    end else begin
      run_open_q  <= run_open_d;
      run_bank_q  <= run_bank_d;
      run_label_q <= run_label_d;
    end
  end

  `DPF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_confirmed_label_o) && $stable(out_bank_o) && $stable(out_last_o))
  `DPF_ASSERT_IMPL(a_label_range, out_valid_o,
    (LABEL_COUNT > 64) || (32'(out_confirmed_label_o) < 32'(LABEL_COUNT)))
  `DPF_ASSERT_IMPL(a_run_same_bank, out_acc && run_open_q, out_bank_o == run_bank_q)
  `DPF_ASSERT_IMPL(a_run_ascending, out_acc && run_open_q,
    (LABEL_COUNT > 64) || (out_confirmed_label_o > run_label_q))

endmodule

bind detection_persistence_filter dpf_checker #(.LABEL_COUNT(LABEL_COUNT)) u_dpf_checker (.*);
